// ===== src/cfct_pkg.sv =====
`timescale 1ns / 1ps
package cfct_pkg;

  // Item kinds on the input stream.
  typedef enum logic [2:0] {
    KIND_OBSERVE = 3'd0,
    KIND_START   = 3'd1,
    KIND_STOP    = 3'd2,
    KIND_RESET   = 3'd3,
    KIND_QUERY   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_HOME,
    ST_READ,
    ST_CHECK,
    ST_UPDATE,
    ST_OUT
  } state_e;

  localparam logic [31:0] HashMult = 32'h9E37_79B9;
  localparam int unsigned MaxLen = 8;

endpackage

// ===== src/can_frame_change_tracker.sv =====
`timescale 1ns / 1ps
// Each item passes ST_IDLE and ST_OUT; start, stop, reset and unknown kinds go straight across.
// A query or observe goes through ST_HASH and ST_HOME for the home slot reduction, then ST_READ
// and ST_CHECK for each probed slot (1..TABLE_ENTRIES), and ST_UPDATE for an observe not dropped.
// Throughput: one item at a time; the next beat is accepted the cycle after the result is taken.
// Reset: rst_ni clears the valid bits, session counter, watch flag and use count at once.
// Stored payloads of an entry are ignored until it is observed again after a reset item.
module can_frame_change_tracker import cfct_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tuser: kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  // tdata: can_id[28:0], direction[29], length_code[33:30], payload[97:34], zeros
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: dirty_mask[7:0], found[8], dropped[9], watching[10], used_entries[17:11], zeros
  output logic [23:0]  m_axis_tdata
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  // Reciprocals for the two-step modulo of the hash by the table size.
  localparam logic [25:0] RecipHi = 26'((64'd1 << 26) / TABLE_ENTRIES + 64'd1);
  localparam logic [35:0] RecipLo = 36'((64'd1 << 36) / TABLE_ENTRIES + 64'd1);

  // Entry layout in memory: id, dir, bytes, seen, dirty, session.
  typedef struct packed {
    logic [28:0] id;
    logic        dir;
    logic [63:0] bytes;
    logic        seen;
    logic [7:0]  dirty;
    logic [31:0] session;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic        vld_q;

  state_e state_q, state_d;
  logic [2:0]  kind_q;
  logic [28:0] id_q;
  logic        dir_q;
  logic [3:0]  len_q;
  logic [63:0] data_q;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] hhi_q, hhi_d;
  logic [CW-1:0] probes_q, probes_d;
  logic [CW-1:0] used_q, used_d;
  logic [31:0] sess_q, sess_d;
  logic        watch_q, watch_d;
  logic [31:0] rst_sess_q, rst_sess_d;  // session number of the last reset item
  logic [7:0]  mask_q, mask_d;
  logic        found_q, found_d, drop_q, drop_d;
  logic        wr_en;
  entry_t      wr_data;
  logic        ovalid_q;

  // Key hash from the registered item.
  logic [31:0] seed, hsh;
  assign seed = {3'b000, id_q} ^ (dir_q ? HashMult : 32'd0);
  assign hsh  = seed ^ (seed >> 16);

  // Home slot: reduce the upper half first, then the folded value.
  logic [41:0] prod_hi;
  logic [15:0] rem_hi;
  logic [25:0] fold;
  logic [61:0] prod_lo;
  logic [25:0] rem_lo;
  logic [AW-1:0] home;
  assign prod_hi = hsh[31:16] * RecipHi;
  assign rem_hi  = hsh[31:16] - 16'(prod_hi[41:26] * TABLE_ENTRIES);
  assign hhi_d   = AW'(rem_hi);
  assign fold    = 26'({hhi_q, hsh[15:0]});
  assign prod_lo = fold * RecipLo;
  assign rem_lo  = fold - 26'(prod_lo[61:36] * TABLE_ENTRIES);
  assign home    = AW'(rem_lo);

  logic [AW-1:0] idx_next;
  assign idx_next = (idx_q == AW'(TABLE_ENTRIES - 1)) ? '0 : idx_q + AW'(1);

  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;

  // Entry view after lazy clearing by a reset item or a new session.
  entry_t cur;
  logic rst_stale;
  logic [3:0] clen;
  logic [7:0] changed;
  logic [63:0] keep;
  logic hit;
  always_comb begin
    cur = rd_q;
    rst_stale = (sess_q - rd_q.session) > (sess_q - rst_sess_q);
    if (!vld_q) begin
      // Empty slot: a new entry starts with no payload and no mask.
      cur.seen  = 1'b0;
      cur.bytes = '0;
      cur.dirty = '0;
    end else if (rst_stale) begin
      // Entry last touched before the latest reset item: forget payload.
      cur.seen  = 1'b0;
      cur.bytes = '0;
    end
    if (rd_q.session != sess_q) cur.dirty = '0;
    clen = (len_q > 4'(MaxLen)) ? 4'(MaxLen) : len_q;
    changed = '0;
    keep = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < clen) begin
        keep[8*b +: 8] = 8'hFF;
        if (cur.seen && (cur.bytes[8*b +: 8] != data_q[8*b +: 8])) changed[b] = 1'b1;
      end
    end
    hit = vld_q && rd_q.id == id_q && rd_q.dir == dir_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_OBSERVE || s_axis_tuser == KIND_QUERY) state_d = ST_HASH;
        else state_d = ST_OUT;
      end
      ST_HASH:  state_d = ST_HOME;
      ST_HOME:  state_d = ST_READ;
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (!vld_q) begin
          state_d = (kind_q == KIND_OBSERVE) ? ST_UPDATE : ST_OUT;
        end else if (hit) begin
          state_d = (kind_q == KIND_OBSERVE) ? ST_UPDATE : ST_OUT;
        end else if (probes_q == CW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and bookkeeping.
  always_comb begin
    idx_d = idx_q;
    probes_d = probes_q;
    used_d = used_q;
    sess_d = sess_q;
    watch_d = watch_q;
    rst_sess_d = rst_sess_q;
    mask_d = mask_q;
    found_d = found_q;
    drop_d = drop_q;
    wr_en = 1'b0;
    wr_data = cur;
    case (state_q)
      ST_IDLE: begin
        probes_d = '0;
        mask_d = '0;
        found_d = 1'b0;
        drop_d = 1'b0;
        if (s_axis_tvalid && s_axis_tready) begin
          case (s_axis_tuser)
            KIND_START: begin
              sess_d = sess_q + 32'd1;
              watch_d = 1'b1;
            end
            KIND_STOP: watch_d = 1'b0;
            KIND_RESET: begin
              sess_d = sess_q + 32'd1;
              rst_sess_d = sess_q + 32'd1;
              watch_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_HOME: idx_d = home;
      ST_CHECK: begin
        if (!vld_q || hit) begin
          found_d = (kind_q == KIND_OBSERVE) || hit;
          if (hit && kind_q == KIND_QUERY) mask_d = rst_stale ? '0 : rd_q.dirty;
        end else if (probes_q == CW'(TABLE_ENTRIES - 1)) begin
          drop_d = (kind_q == KIND_OBSERVE);
        end else begin
          idx_d = idx_next;
          probes_d = probes_q + CW'(1);
        end
      end
      ST_UPDATE: begin
        wr_en = 1'b1;
        if (!vld_q) begin
          wr_data.id = id_q;
          wr_data.dir = dir_q;
          wr_data.bytes = '0;
          wr_data.seen = 1'b0;
          wr_data.dirty = '0;
          if (used_q < CW'(TABLE_ENTRIES)) used_d = used_q + CW'(1);
        end
        wr_data.session = sess_q;
        if (watch_q) wr_data.dirty = wr_data.dirty | changed;
        wr_data.bytes = (wr_data.bytes & ~keep) | (data_q & keep);
        wr_data.seen = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      used_q <= '0;
      sess_q <= '0;
      rst_sess_q <= '0;
      watch_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      sess_q <= sess_d;
      rst_sess_q <= rst_sess_d;
      watch_q <= watch_d;
      if (wr_en) valid_q[idx_q] <= 1'b1;
      if (state_q == ST_OUT) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    hhi_q <= hhi_d;
    probes_q <= probes_d;
    mask_q <= mask_d;
    found_q <= found_d;
    drop_q <= drop_d;
    vld_q <= valid_q[idx_q];
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      id_q <= s_axis_tdata[28:0];
      dir_q <= s_axis_tdata[29];
      len_q <= s_axis_tdata[33:30];
      data_q <= s_axis_tdata[97:34];
    end
    if (state_q == ST_OUT) begin
      m_axis_tdata <= {6'd0, 7'(used_q), watch_q, drop_q, found_q, mask_q};
    end
  end

  // Slot memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[idx_q] <= wr_data;
    rd_q <= mem[idx_q];
  end

endmodule

// ===== dv/tb_can_frame_change_tracker.sv =====
`timescale 1ns / 1ps
module tb_can_frame_change_tracker;
  import cfct_pkg::*;

  localparam int unsigned NumSlots = 64;

  // Result beat fields, from the highest bit down.
  typedef struct packed {
    logic [6:0] used_entries;
    logic       watching;
    logic       dropped;
    logic       found;
    logic [7:0] dirty_mask;
  } tracker_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [2:0]   s_axis_tuser = '0;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;

  can_frame_change_tracker #(.TABLE_ENTRIES(NumSlots)) DUT (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the tracker table.
  logic        tbl_valid [NumSlots];
  logic [28:0] tbl_id [NumSlots];
  logic        tbl_dir [NumSlots];
  logic [63:0] tbl_bytes [NumSlots];
  logic        tbl_seen [NumSlots];
  logic [7:0]  tbl_dirty [NumSlots];
  logic [31:0] tbl_session [NumSlots];
  logic [31:0] session_num;
  logic        watch_active;
  int unsigned used_count;

  tracker_result_t pending_results[$];
  int  error_count = 0;
  bit  idle_enable = 1'b1;
  int  rx_hold_total = 0;
  int  rx_hold_cycles = 0;
  logic [28:0] known_ids[$];
  logic        known_dirs[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned home_of(logic [28:0] id, logic dir);
    logic [31:0] seed;
    logic [31:0] h;
    seed = {3'b0, id} ^ (dir ? 32'h9E37_79B9 : 32'h0);
    h = seed ^ (seed >> 16);
    return h % NumSlots;
  endfunction

  // Returns slot index or -1; with make set, claims the first empty slot.
  function automatic int find_slot(logic [28:0] id, logic dir, bit make);
    int unsigned b;
    int unsigned i;
    b = home_of(id, dir);
    for (int p = 0; p < NumSlots; p++) begin
      i = (b + p) % NumSlots;
      if (!tbl_valid[i]) begin
        if (!make) return -1;
        tbl_valid[i] = 1'b1;
        tbl_id[i] = id;
        tbl_dir[i] = dir;
        tbl_bytes[i] = '0;
        tbl_seen[i] = 1'b0;
        tbl_dirty[i] = '0;
        tbl_session[i] = session_num;
        if (used_count < NumSlots) used_count++;
        return i;
      end
      if (tbl_id[i] == id && tbl_dir[i] == dir) return i;
    end
    return -1;
  endfunction

  function automatic tracker_result_t track_item(logic [2:0] kind, logic [28:0] id,
                                                 logic dir, logic [3:0] dlc,
                                                 logic [63:0] data);
    tracker_result_t r;
    int s;
    int unsigned len;
    logic [7:0] changed;
    logic [63:0] keep;
    r = '0;
    changed = '0;
    case (kind)
      KIND_OBSERVE: begin
        s = find_slot(id, dir, 1'b1);
        if (s < 0) begin
          r.dropped = 1'b1;
        end else begin
          r.found = 1'b1;
          if (tbl_session[s] != session_num) begin
            tbl_dirty[s] = '0;
            tbl_session[s] = session_num;
          end
          len = (dlc > 8) ? 8 : dlc;
          if (tbl_seen[s])
            for (int b = 0; b < len; b++)
              if (tbl_bytes[s][8*b +: 8] != data[8*b +: 8]) changed[b] = 1'b1;
          if (watch_active) tbl_dirty[s] |= changed;
          keep = '0;
          for (int b = 0; b < len; b++) keep[8*b +: 8] = 8'hFF;
          tbl_bytes[s] = (tbl_bytes[s] & ~keep) | (data & keep);
          tbl_seen[s] = 1'b1;
        end
      end
      KIND_START: begin
        session_num++;
        watch_active = 1'b1;
      end
      KIND_STOP: watch_active = 1'b0;
      KIND_RESET: begin
        watch_active = 1'b0;
        session_num++;
        for (int i = 0; i < NumSlots; i++)
          if (tbl_valid[i]) begin
            tbl_dirty[i] = '0;
            tbl_session[i] = session_num;
            tbl_seen[i] = 1'b0;
            tbl_bytes[i] = '0;
          end
      end
      KIND_QUERY: begin
        s = find_slot(id, dir, 1'b0);
        if (s >= 0) begin
          r.found = 1'b1;
          r.dirty_mask = tbl_dirty[s];
        end
      end
      default: ;
    endcase
    r.watching = watch_active;
    r.used_entries = used_count[6:0];
    return r;
  endfunction

  // Offers one beat from a falling edge on and returns at the accepting rising edge.
  task automatic send_item(input logic [2:0] kind, input logic [28:0] id, input logic dir,
                           input logic [3:0] dlc, input logic [63:0] data);
    @(negedge clk_i);
    while (idle_enable && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'b0, data, dlc, dir, id};
    pending_results.push_back(track_item(kind, id, dir, dlc, data));
    if (kind == KIND_OBSERVE) begin
      known_ids.push_back(id);
      known_dirs.push_back(dir);
    end
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4 + NumSlots + 4) @(negedge clk_i);
  endtask

  // Receiver readiness, with a long hold-off counted here.
  always @(negedge clk_i) begin
    if (rx_hold_cycles < rx_hold_total) begin
      rx_hold_cycles <= rx_hold_cycles + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_enable && $urandom_range(99) < 38);
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk_i) begin
    tracker_result_t got;
    tracker_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[17:0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_axis_tdata), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.dirty_mask != want.dirty_mask)
          report_mismatch("dirty_mask", 32'(got.dirty_mask), 32'(want.dirty_mask));
        if (got.found != want.found)
          report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.dropped != want.dropped)
          report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
        if (got.watching != want.watching)
          report_mismatch("watching", 32'(got.watching), 32'(want.watching));
        if (got.used_entries != want.used_entries)
          report_mismatch("used_entries", 32'(got.used_entries), 32'(want.used_entries));
      end
    end
  end

  function automatic logic [63:0] rand_payload();
    return {$urandom(), $urandom()};
  endfunction

  // Extremes of fields, every kind, unknown kinds, absent-key query.
  task automatic test_directed();
    send_item(KIND_QUERY, 29'h1FFF_FFFF, 1'b1, 4'd0, '0);
    send_item(KIND_OBSERVE, 29'h0, 1'b0, 4'd8, 64'h0);
    send_item(KIND_OBSERVE, 29'h0, 1'b0, 4'd8, '1);
    send_item(KIND_START, 29'h0, 1'b0, 4'd0, '0);
    send_item(KIND_OBSERVE, 29'h0, 1'b0, 4'd15, 64'h00FF_00FF_00FF_00FF);
    send_item(KIND_OBSERVE, 29'h0, 1'b0, 4'd3, 64'hFFFF_FFFF_FFFF_FF00);
    send_item(KIND_QUERY, 29'h0, 1'b0, 4'd0, '0);
    send_item(KIND_OBSERVE, 29'h1FFF_FFFF, 1'b1, 4'd0, '1);
    send_item(KIND_OBSERVE, 29'h1FFF_FFFF, 1'b1, 4'd8, '0);
    send_item(KIND_OBSERVE, 29'h0, 1'b1, 4'd8, 64'h1234);
    send_item(KIND_START, 29'h0, 1'b0, 4'd0, '0);
    // Stale mask from the earlier session, then a clearing observe.
    send_item(KIND_QUERY, 29'h0, 1'b0, 4'd0, '0);
    send_item(KIND_OBSERVE, 29'h0, 1'b0, 4'd1, '0);
    send_item(KIND_QUERY, 29'h0, 1'b0, 4'd0, '0);
    send_item(KIND_STOP, 29'h0, 1'b0, 4'd0, '0);
    send_item(KIND_OBSERVE, 29'h0, 1'b0, 4'd8, 64'h55);
    send_item(KIND_RESET, 29'h0, 1'b0, 4'd0, '0);
    send_item(KIND_START, 29'h0, 1'b0, 4'd0, '0);
    send_item(KIND_OBSERVE, 29'h0, 1'b0, 4'd8, 64'h77);
    send_item(KIND_QUERY, 29'h0, 1'b0, 4'd0, '0);
    for (int k = 5; k < 8; k++) send_item(3'(k), 29'h1555_5555, 1'b1, 4'd9, rand_payload());
  endtask

  // Mostly observe/query on a small reused key set with watch control.
  task automatic test_random(input int count, input int key_space);
    int pick;
    logic [28:0] id;
    logic dir;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (known_ids.size() != 0 && $urandom_range(3) != 0) begin
        int j;
        j = $urandom_range(known_ids.size() - 1);
        id = known_ids[j];
        dir = known_dirs[j];
      end else begin
        id = ($urandom_range(3) == 0) ? 29'($urandom()) : 29'($urandom_range(key_space));
        dir = 1'($urandom());
      end
      if (pick < 55)
        send_item(KIND_OBSERVE, id, dir, 4'($urandom()),
                  ($urandom_range(1) == 0) ? rand_payload() : 64'($urandom_range(3)));
      else if (pick < 80) send_item(KIND_QUERY, id, dir, 4'($urandom()), rand_payload());
      else if (pick < 88) send_item(KIND_START, id, dir, 4'($urandom()), rand_payload());
      else if (pick < 94) send_item(KIND_STOP, id, dir, 4'($urandom()), rand_payload());
      else if (pick < 97) send_item(KIND_RESET, id, dir, 4'($urandom()), rand_payload());
      else send_item(3'($urandom_range(7, 5)), id, dir, 4'($urandom()), rand_payload());
    end
  endtask

  // Fill the table past capacity so new keys drop, then query absent keys.
  task automatic test_full_table();
    for (int n = 0; n < NumSlots + 6; n++)
      send_item(KIND_OBSERVE, 29'($urandom()), 1'($urandom()), 4'($urandom()), rand_payload());
    for (int n = 0; n < 6; n++)
      send_item(KIND_QUERY, 29'($urandom()), 1'($urandom()), 4'd0, '0);
  endtask

  // Receiver holds off while the sender keeps offering beats.
  task automatic test_backpressure();
    rx_hold_total = 300;
    test_random(10, 40);
  endtask

  // No idling on either side for a stretch.
  task automatic test_no_idle();
    idle_enable = 1'b0;
    test_random(150, 40);
    idle_enable = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_bytes[i] = '0;
      tbl_seen[i] = 1'b0;
      tbl_dirty[i] = '0;
      tbl_session[i] = '0;
    end
    session_num = '0;
    watch_active = 1'b0;
    used_count = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500, 40);
    wait_drained();
    test_backpressure();
    test_no_idle();
    test_random(200, 60);
    test_full_table();
    test_random(250, 60);
    wait_drained();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
